// ----- sv/kscf_pkg.sv -----
// Package: word types, frame constants and frame byte lookup for the key scan framer.
`timescale 1ns / 1ps
`default_nettype none
package kscf_pkg;

  localparam logic [7:0] KEY_BYTE_ODD  = 8'h01;
  localparam logic [7:0] KEY_BYTE_EVEN = 8'h08;
  localparam logic [7:0] FRAME_HEAD    = 8'h7A;
  localparam logic [7:0] FRAME_ADDR    = 8'h01;
  localparam logic [7:0] FRAME_CMD     = 8'h02;
  localparam logic [7:0] FRAME_PAD     = 8'h00;
  localparam logic [7:0] FRAME_TAIL    = 8'h67;
  localparam logic [2:0] FRAME_LAST    = 3'd7;

  localparam logic [2:0] IDX_HEAD  = 3'd0;
  localparam logic [2:0] IDX_ADDR  = 3'd1;
  localparam logic [2:0] IDX_CMD   = 3'd2;
  localparam logic [2:0] IDX_CODE  = 3'd3;
  localparam logic [2:0] IDX_PAD   = 3'd4;
  localparam logic [2:0] IDX_SUMLO = 3'd5;
  localparam logic [2:0] IDX_SUMHI = 3'd6;
  localparam logic [2:0] IDX_TAIL  = 3'd7;

  localparam logic [1:0] MODE_NONE   = 2'd0;
  localparam logic [1:0] MODE_KEY_ON = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  typedef struct packed {
    logic [7:0] key_byte0;
    logic [7:0] key_byte1;
    logic [7:0] key_byte2;
    logic [7:0] key_byte3;
    logic [7:0] key_byte4;
    logic       aux_pin_low;
    logic       awaiting_key;
  } scan_word_t;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_valid;
    logic       last_of_run;
    logic [4:0] confirmed_key;
    logic [3:0] released_key;
    logic [1:0] mode_request;
  } report_word_t;

  // Byte idx of the report frame for a given key code.
  function automatic logic [7:0] frame_byte_at(input logic [2:0] idx, input logic [4:0] code);
    logic [15:0] sum;
    logic [7:0]  b;
    sum = 16'(FRAME_ADDR) + 16'(FRAME_CMD) + 16'(code) + 16'(FRAME_PAD);
    unique case (idx)
      IDX_HEAD:  b = FRAME_HEAD;
      IDX_ADDR:  b = FRAME_ADDR;
      IDX_CMD:   b = FRAME_CMD;
      IDX_CODE:  b = 8'(code);
      IDX_PAD:   b = FRAME_PAD;
      IDX_SUMLO: b = sum[7:0];
      IDX_SUMHI: b = sum[15:8];
      IDX_TAIL:  b = FRAME_TAIL;
      default:   b = FRAME_PAD;
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ----- sv/key_scan_confirm_framer.sv -----
// Top level: keypad scan decode, key confirmation and report frame emission.
`timescale 1ns / 1ps
`default_nettype none
// One scan word enters through an input register, where the key is decoded; once the
// result register is free, the scan updates the confirmation state and loads it, from
// which one report word leaves per cycle while report_stall is low. A scan that
// confirms a key while awaiting_key is set yields eight words (the frame 7A 01 02
// code 00 sumlo sumhi 67); every other scan yields one word with frame_valid low.
// The first report word shows on the report port once the scan is loaded into the
// result register. The report side sets the rate: a new scan is taken every cycle
// while scans produce single words and report_stall is low; during a frame the next
// scan waits for its last byte, as the byte counter in the result register serves
// one scan at a time. The user must write slave_device via cfg_we/cfg_data only
// while the block is idle (not enforced by the block); it adds ten to confirmed codes.
module key_scan_confirm_framer (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic                  cfg_data,
  input  wire logic                  scan_valid,
  output logic                       scan_stall,
  input  wire kscf_pkg::scan_word_t  scan,
  output logic                       report_valid,
  input  wire logic                  report_stall,
  output kscf_pkg::report_word_t     report
);
  import kscf_pkg::*;

  // Configuration
  logic slave_device;

  // Input register
  logic       s1_valid;
  scan_word_t s1_word;

  // Key state
  logic [3:0] prev_key;
  logic       release_armed;

  // Result register
  logic       res_valid;
  logic       res_send;
  logic [4:0] res_code;
  logic [3:0] res_released;
  logic [1:0] res_mode;
  logic [2:0] res_index;

  // Decode and decision
  logic [3:0] cur_key;
  logic       is_release;
  logic       is_change;
  logic       is_confirm;
  logic [4:0] code_next;

  logic res_last;
  logic word_done;
  logic run_done;
  logic s2_load;
  logic scan_take;

  // Decode the key: later bytes override earlier ones.
  always_comb begin
    logic [7:0] bytes [5];
    logic [7:0] v;
    bytes[0] = s1_word.key_byte0;
    bytes[1] = s1_word.aux_pin_low ? KEY_BYTE_ODD : s1_word.key_byte1;
    bytes[2] = s1_word.key_byte2;
    bytes[3] = s1_word.key_byte3;
    bytes[4] = s1_word.key_byte4;
    cur_key = 4'd0;
    for (int b = 0; b < 5; b++) begin
      v = bytes[b];
      if (v == KEY_BYTE_ODD) begin
        cur_key = 4'(2 * b + 1);
      end else if (v == KEY_BYTE_EVEN) begin
        cur_key = 4'(2 * b + 2);
      end
    end
  end

  assign is_release = (prev_key != 4'd0) && (cur_key == 4'd0);
  assign is_change  = (prev_key != 4'd0) && (cur_key != 4'd0) && (cur_key != prev_key);
  assign is_confirm = !is_release && !is_change && (cur_key != 4'd0)
                      && (cur_key == prev_key) && release_armed;
  assign code_next  = 5'(cur_key) + (slave_device ? 5'd10 : 5'd0);

  // Handshake: the result register frees on its last word; the input register
  // advances into it then or when it is empty.
  assign res_last   = !res_send || (res_index == FRAME_LAST);
  assign word_done  = res_valid && !report_stall;
  assign run_done   = word_done && res_last;
  assign s2_load    = s1_valid && (!res_valid || run_done);
  assign scan_stall = s1_valid && !s2_load;
  assign scan_take  = scan_valid && !scan_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_device <= 1'b0;
    end else if (cfg_we) begin
      slave_device <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (scan_take) begin
      s1_valid <= 1'b1;
    end else if (s2_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (scan_take) begin
      s1_word <= scan;
    end
  end

  // Key state advances as a scan moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_key      <= 4'd0;
      release_armed <= 1'b1;
    end else if (s2_load) begin
      prev_key <= cur_key;
      priority if (is_release) begin
        release_armed <= 1'b1;
      end else if (is_change) begin
        release_armed <= 1'b1;
      end else if (is_confirm) begin
        release_armed <= 1'b0;
      end else begin
        release_armed <= release_armed;
      end
    end
  end

  // Result register and frame byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      res_index <= 3'd0;
    end else if (s2_load) begin
      res_valid <= 1'b1;
      res_index <= 3'd0;
    end else if (run_done) begin
      res_valid <= 1'b0;
      res_index <= 3'd0;
    end else if (word_done) begin
      res_index <= res_index + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      res_send     <= is_confirm && s1_word.awaiting_key;
      res_code     <= is_confirm ? code_next : 5'd0;
      res_released <= is_release ? prev_key : 4'd0;
      if (is_confirm) begin
        res_mode <= s1_word.awaiting_key ? MODE_KEY_ON : MODE_FINISH;
      end else begin
        res_mode <= MODE_NONE;
      end
    end
  end

  // Output word straight from the result register
  assign report_valid         = res_valid;
  assign report.frame_byte    = res_send ? frame_byte_at(res_index, res_code) : 8'd0;
  assign report.frame_valid   = res_send;
  assign report.last_of_run   = res_last;
  assign report.confirmed_key = res_code;
  assign report.released_key  = res_released;
  assign report.mode_request  = res_mode;

  // The byte counter runs only inside a frame.
  a_index_in_frame: assert property (@(posedge clk) disable iff (rst)
    (res_valid && (res_index != 3'd0)) |-> res_send)
    else $error("frame byte counter moved outside a frame");

  // A delivered word that is not the last advances the counter by one.
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (word_done && !res_last) |=> (res_valid && (res_index == $past(res_index) + 3'd1)))
    else $error("frame byte counter skipped or lost the run");

  // A confirmation disarms further confirmations.
  a_confirm_disarms: assert property (@(posedge clk) disable iff (rst)
    (s2_load && is_confirm) |=> !release_armed)
    else $error("confirmation left the release mark armed");

  // A frame is sent only with key-on mode and a nonzero code.
  a_frame_mode: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_send) |-> ((res_mode == MODE_KEY_ON) && (res_code != 5'd0)))
    else $error("frame without key-on request");

endmodule
`default_nettype wire

// ----- sim/kscf_checker.sv -----
// Report checker: predicts key scan results and compares the report words that leave the block.
`timescale 1ns / 1ps
module kscf_report_checker (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic                   cfg_data,
  input  logic                   scan_valid,
  input  logic                   scan_stall,
  input  kscf_pkg::scan_word_t   scan,
  input  logic                   report_valid,
  input  logic                   report_stall,
  input  kscf_pkg::report_word_t report,
  output int                     fail_count,
  output int                     pending
);
  import kscf_pkg::*;

  report_word_t expected_reports[$];

  logic       slave_mode;
  logic [3:0] last_key;
  logic [3:0] confirm_mark;
  logic [4:0] held_code;

  function automatic logic [3:0] decode_scan(input scan_word_t w);
    logic [7:0] key_bytes [5];
    logic [3:0] key;
    key_bytes[0] = w.key_byte0;
    key_bytes[1] = w.aux_pin_low ? KEY_BYTE_ODD : w.key_byte1;
    key_bytes[2] = w.key_byte2;
    key_bytes[3] = w.key_byte3;
    key_bytes[4] = w.key_byte4;
    key = 4'd0;
    for (int b = 0; b < 5; b++) begin
      if (key_bytes[b] == KEY_BYTE_ODD)
        key = 4'(2 * b + 1);
      else if (key_bytes[b] == KEY_BYTE_EVEN)
        key = 4'(2 * b + 2);
    end
    return key;
  endfunction

  task automatic predict_scan(input scan_word_t w);
    logic [3:0]   cur;
    logic [4:0]   code;
    logic [15:0]  sum;
    logic [7:0]   frame [8];
    logic         send;
    report_word_t r;
    cur = decode_scan(w);
    send = 1'b0;
    r = '0;
    if (last_key != 4'd0 && cur == 4'd0) begin
      confirm_mark = last_key;
      r.released_key = last_key;
    end else if (last_key != 4'd0 && cur != 4'd0 && cur != last_key) begin
      held_code = 5'd0;
      confirm_mark = 4'd1;
    end else if (cur != 4'd0 && cur == last_key && confirm_mark != 4'd0) begin
      code = 5'(cur) + (slave_mode ? 5'd10 : 5'd0);
      held_code = code;
      confirm_mark = 4'd0;
      r.confirmed_key = code;
      if (w.awaiting_key) begin
        sum = 16'(FRAME_ADDR) + 16'(FRAME_CMD) + 16'(code) + 16'(FRAME_PAD);
        frame[0] = FRAME_HEAD;
        frame[1] = FRAME_ADDR;
        frame[2] = FRAME_CMD;
        frame[3] = 8'(code);
        frame[4] = FRAME_PAD;
        frame[5] = sum[7:0];
        frame[6] = sum[15:8];
        frame[7] = FRAME_TAIL;
        send = 1'b1;
        r.mode_request = MODE_KEY_ON;
      end else begin
        r.mode_request = MODE_FINISH;
      end
    end
    last_key = cur;
    if (send) begin
      for (int k = 0; k < 8; k++) begin
        r.frame_byte  = frame[k];
        r.frame_valid = 1'b1;
        r.last_of_run = (k == 7);
        expected_reports.push_back(r);
      end
    end else begin
      r.last_of_run = 1'b1;
      expected_reports.push_back(r);
    end
  endtask

  task automatic check_report(input report_word_t got);
    report_word_t want;
    logic         bad;
    if (expected_reports.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("unexpected report word %h with nothing expected", got);
    end else begin
      want = expected_reports.pop_front();
      bad = (got.frame_byte    !== want.frame_byte)
         || (got.frame_valid   !== want.frame_valid)
         || (got.last_of_run   !== want.last_of_run)
         || (got.confirmed_key !== want.confirmed_key)
         || (got.released_key  !== want.released_key)
         || (got.mode_request  !== want.mode_request);
      if (bad) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("report mismatch: expected byte %h fv %b last %b conf %0d rel %0d mode %0d",
                   want.frame_byte, want.frame_valid, want.last_of_run,
                   want.confirmed_key, want.released_key, want.mode_request);
          $display("                 got      byte %h fv %b last %b conf %0d rel %0d mode %0d",
                   got.frame_byte, got.frame_valid, got.last_of_run,
                   got.confirmed_key, got.released_key, got.mode_request);
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending = 0;
  end

  always @(posedge clk) begin
    if (rst) begin
      slave_mode = 1'b0;
      last_key = 4'd0;
      confirm_mark = 4'd1;
      held_code = 5'd0;
      expected_reports.delete();
    end else begin
      if (report_valid && !report_stall)
        check_report(report);
      if (cfg_we)
        slave_mode = cfg_data;
      if (scan_valid && !scan_stall)
        predict_scan(scan);
    end
    pending = expected_reports.size();
  end

endmodule

// ----- sim/testbench.sv -----
// Testbench top: clock, reset, scan stimulus, report stall pattern and final verdict.
`timescale 1ns / 1ps
module testbench;
  import kscf_pkg::*;

  logic         clk;
  logic         rst;
  logic         cfg_we;
  logic         cfg_data;
  logic         scan_valid;
  logic         scan_stall;
  scan_word_t   scan;
  logic         report_valid;
  logic         report_stall = 1'b0;
  report_word_t report;
  int           fail_count;
  int           pending;

  // sender pacing: words left in the current burst
  int burst_left = 0;

  key_scan_confirm_framer DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .scan         (scan),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report)
  );

  kscf_report_checker checker_i (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .scan_valid   (scan_valid),
    .scan_stall   (scan_stall),
    .scan         (scan),
    .report_valid (report_valid),
    .report_stall (report_stall),
    .report       (report),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Receiver back-pressure: whenever the phase counter wraps, pick a fresh 16-bit
  // stall pattern and walk through it one bit per cycle. Some windows never stall,
  // some stall in long blocks, some at random, so stalls land on every byte of a frame.
  logic [15:0] stall_pattern = 16'h0000;
  logic [3:0]  stall_phase = 4'd0;
  always @(negedge clk) begin
    if (stall_phase == 4'd0) begin
      case ($urandom_range(0, 4))
        0, 1:    stall_pattern = 16'h0000;
        2:       stall_pattern = 16'($urandom);
        3:       stall_pattern = 16'($urandom & $urandom);
        default: stall_pattern = 16'hFF00 >> $urandom_range(0, 8);
      endcase
    end
    report_stall <= stall_pattern[stall_phase];
    stall_phase = stall_phase + 4'd1;
  end

  // Build a scan word from raw fields.
  function automatic scan_word_t mk_scan(input logic [7:0] b0, input logic [7:0] b1,
                                         input logic [7:0] b2, input logic [7:0] b3,
                                         input logic [7:0] b4, input logic aux,
                                         input logic await_key);
    scan_word_t w;
    w.key_byte0 = b0;
    w.key_byte1 = b1;
    w.key_byte2 = b2;
    w.key_byte3 = b3;
    w.key_byte4 = b4;
    w.aux_pin_low = aux;
    w.awaiting_key = await_key;
    return w;
  endfunction

  // A byte that decodes to no key: often zero, otherwise any value but the two key codes.
  function automatic logic [7:0] blank_byte();
    logic [7:0] v;
    v = 8'($urandom);
    if ($urandom_range(0, 1) == 0)
      v = 8'h00;
    if (v == KEY_BYTE_ODD || v == KEY_BYTE_EVEN)
      v = v ^ 8'h10;
    return v;
  endfunction

  // Scan word that decodes to key (0 = no key) with noise in every byte that the
  // decode ignores. Bytes below the key byte may carry keys that get overridden.
  function automatic scan_word_t scan_for_key(input int key, input logic await_key);
    logic [7:0] kb [5];
    logic       aux;
    int         pos;
    for (int b = 0; b < 5; b++)
      kb[b] = blank_byte();
    aux = 1'b0;
    if (key != 0) begin
      pos = (key - 1) / 2;
      kb[pos] = (key % 2 == 1) ? KEY_BYTE_ODD : KEY_BYTE_EVEN;
      for (int b = 0; b < pos; b++) begin
        if ($urandom_range(0, 3) == 0)
          kb[b] = ($urandom_range(0, 1) == 0) ? KEY_BYTE_ODD : KEY_BYTE_EVEN;
      end
      // the aux pin reads as key 3, so it may only be low where a later byte wins or the key is 3
      if (pos >= 2 || key == 3)
        aux = 1'($urandom_range(0, 1));
    end
    return mk_scan(kb[0], kb[1], kb[2], kb[3], kb[4], aux, await_key);
  endfunction

  // Insert a gap between bursts; now and then run a long burst with no gap at all.
  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 4) == 0) begin
        gap = 0;
        burst_left = 30;
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 10);
      end
      repeat (gap) @(negedge clk) scan_valid <= 1'b0;
    end
    burst_left--;
  endtask

  // Present one scan word at the falling edge and hold it until it is taken.
  task automatic send_scan(input scan_word_t w);
    pace_sender();
    @(negedge clk);
    scan_valid <= 1'b1;
    scan <= w;
    do @(posedge clk); while (scan_stall);
  endtask

  // Drop valid and wait until every expected report word has come back.
  task automatic drain_reports();
    @(negedge clk) scan_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write slave_device while the block is idle.
  task automatic set_slave(input logic v);
    drain_reports();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random scans: mostly a key held over a few scans so confirmations, holds,
  // releases and key changes all happen, with some fully random noise words.
  task automatic random_scans(input int count);
    int         sent;
    int         key;
    int         reps;
    logic       await_key;
    scan_word_t w;
    sent = 0;
    while (sent < count) begin
      key = $urandom_range(0, 10);
      reps = $urandom_range(1, 4);
      await_key = 1'($urandom_range(0, 1));
      for (int i = 0; i < reps; i++) begin
        if ($urandom_range(0, 9) == 0)
          w = mk_scan(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                      8'($urandom), 1'($urandom), 1'($urandom));
        else begin
          if ($urandom_range(0, 3) == 0)
            await_key = ~await_key;
          w = scan_for_key(key, await_key);
        end
        send_scan(w);
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = 1'b0;
    scan_valid = 1'b0;
    scan = '0;
    repeat (12) @(negedge clk);
    rst <= 1'b0;

    // directed, slave off
    set_slave(1'b0);
    // idle scan, no key
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));
    // aux pin low forces key 3 among unknown bytes; confirm with a frame, then hold
    send_scan(mk_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_scan(mk_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    send_scan(mk_scan(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1));
    // release key 3
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // key 1 confirmed with a frame
    send_scan(mk_scan(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    send_scan(mk_scan(8'h01, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1));
    // change to key 10 (last byte wins), then confirm without awaiting: finish
    send_scan(mk_scan(8'h01, 8'h00, 8'h00, 8'h00, 8'h08, 1'b0, 1'b0));
    send_scan(mk_scan(8'h01, 8'h00, 8'h00, 8'h00, 8'h08, 1'b0, 1'b0));
    // change to key 9, then confirm it under earlier key bytes
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 1'b0, 1'b0));
    send_scan(mk_scan(8'h08, 8'h08, 8'h08, 8'h08, 8'h01, 1'b0, 1'b1));
    // bytes near the key codes decode to nothing: release 9
    send_scan(mk_scan(8'h09, 8'h80, 8'h10, 8'h02, 8'h04, 1'b0, 1'b1));

    // directed, slave on
    set_slave(1'b1);
    // key 10 gives the highest code, 20
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 1'b0, 1'b1));
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h08, 1'b0, 1'b1));
    // aux key 3 overridden by key 8; change, confirm to finish, release
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 1'b1, 1'b0));
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 1'b1, 1'b0));
    send_scan(mk_scan(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b0));

    // random phases, alternating the slave setting
    set_slave(1'b0);
    random_scans(48);
    set_slave(1'b1);
    random_scans(48);
    set_slave(1'b0);
    random_scans(48);
    set_slave(1'b1);
    random_scans(48);

    // wait out the last words, then give the verdict
    drain_reports();
    repeat (10) @(negedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // hang guard
  initial begin
    #2_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
